@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SOB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SOB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sob_pkg.sv @@
package sob_pkg;

	// Register indexes on the config port.
	localparam logic [1:0] REG_OBSTACLE_COUNT = 2'd0;
	localparam logic [1:0] REG_ROBOT_RADIUS   = 2'd1;
	localparam logic [1:0] REG_BALL_RADIUS    = 2'd2;
	localparam logic [1:0] REG_END_SLACK      = 2'd3;

	localparam int CFG_W    = 12;
	localparam int COUNT_W  = 5;
	localparam int RADIUS_W = 12;
	localparam int INDEX_W  = 4;

	// Input kinds carried in tuser.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_MUL,
		ST_LEN_ADD,
		ST_SQI,
		ST_SQRT,
		ST_WIN,
		ST_WSQ,
		ST_RD,
		ST_DIF,
		ST_MUL,
		ST_ADD,
		ST_MUL2,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic len_mul;
		logic len_add;
		logic sqrt_init;
		logic sqrt_step;
		logic win;
		logic wsq;
		logic rd;
		logic dif;
		logic mul;
		logic add;
		logic mul2;
		logic cmp;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic acc;
		logic is_query;
		logic zero_len;
		logic sqrt_last;
		logic j_end;
		logic hit;
		logic out_busy;
	} status_t;

endpackage

@@ sv/sob_ctrl.sv @@
module sob_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  sob_pkg::status_t st,
	output sob_pkg::cmd_t    cmd
);

	sob_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sob_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			sob_pkg::ST_IDLE: begin
				cmd.take = !st.out_busy;
				if (st.acc) begin
					state_d = st.is_query ? sob_pkg::ST_LEN_MUL : sob_pkg::ST_DONE;
				end
			end
			sob_pkg::ST_LEN_MUL: begin
				cmd.len_mul = 1'b1;
				state_d = sob_pkg::ST_LEN_ADD;
			end
			sob_pkg::ST_LEN_ADD: begin
				cmd.len_add = 1'b1;
				state_d = sob_pkg::ST_SQI;
			end
			sob_pkg::ST_SQI: begin
				if (st.zero_len) begin
					state_d = sob_pkg::ST_DONE;
				end else begin
					cmd.sqrt_init = 1'b1;
					state_d = sob_pkg::ST_SQRT;
				end
			end
			sob_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (st.sqrt_last) state_d = sob_pkg::ST_WIN;
			end
			sob_pkg::ST_WIN: begin
				cmd.win = 1'b1;
				state_d = sob_pkg::ST_WSQ;
			end
			sob_pkg::ST_WSQ: begin
				cmd.wsq = 1'b1;
				state_d = sob_pkg::ST_RD;
			end
			sob_pkg::ST_RD: begin
				if (st.j_end) begin
					state_d = sob_pkg::ST_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = sob_pkg::ST_DIF;
				end
			end
			sob_pkg::ST_DIF: begin
				cmd.dif = 1'b1;
				state_d = sob_pkg::ST_MUL;
			end
			sob_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = sob_pkg::ST_ADD;
			end
			sob_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				state_d = sob_pkg::ST_MUL2;
			end
			sob_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = sob_pkg::ST_CMP;
			end
			sob_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = st.hit ? sob_pkg::ST_DONE : sob_pkg::ST_RD;
			end
			sob_pkg::ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = sob_pkg::ST_IDLE;
			end
			default: begin
				state_d = sob_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/sob_dp.sv @@
module sob_dp #(
	parameter int MAX_OBSTACLES = 16,
	parameter int COORD_BITS    = 14,
	parameter int IN_W          = 96
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [sob_pkg::CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tuser,
	input  sob_pkg::cmd_t    cmd,
	output sob_pkg::status_t st
);

	localparam int C    = COORD_BITS;
	localparam int AW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int JW   = $clog2(MAX_OBSTACLES + 1);
	localparam int DW   = C + 1;            // coordinate difference
	localparam int SQW  = 2 * C + 2;        // one square
	localparam int LW   = 2 * C + 3;        // sum of two squares
	localparam int E    = 2 * C + 4;        // even width for the root
	localparam int K    = C + 2;            // root bits, one per step
	localparam int KW   = $clog2(K);
	localparam int WW   = ((K > sob_pkg::RADIUS_W) ? K : sob_pkg::RADIUS_W) + 1;
	localparam int WSW  = 2 * WW;
	localparam int RRW  = 2 * sob_pkg::RADIUS_W;
	localparam int CRW  = 2 * C + 3;        // cross product
	localparam int A2W  = 2 * CRW;
	localparam int RLW  = 2 * sob_pkg::RADIUS_W + LW;
	localparam int PW   = (A2W > RLW) ? A2W : RLW;
	localparam int ENT  = 2 * C + 1;

	// Input word offsets
	localparam int O_IDX  = 0;
	localparam int O_OX   = O_IDX + sob_pkg::INDEX_W;
	localparam int O_OY   = O_OX + C;
	localparam int O_BALL = O_OY + C;
	localparam int O_SX   = O_BALL + 1;
	localparam int O_SY   = O_SX + C;
	localparam int O_EX   = O_SY + C;
	localparam int O_EY   = O_EX + C;

	// Config registers
	logic [sob_pkg::COUNT_W-1:0]  count_q;
	logic [sob_pkg::RADIUS_W-1:0] robot_r_q, ball_r_q, slack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			robot_r_q <= '0;
			ball_r_q  <= '0;
			slack_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				sob_pkg::REG_OBSTACLE_COUNT: count_q <= cfg_data[sob_pkg::COUNT_W-1:0];
				sob_pkg::REG_ROBOT_RADIUS:   robot_r_q <= cfg_data;
				sob_pkg::REG_BALL_RADIUS:    ball_r_q <= cfg_data;
				sob_pkg::REG_END_SLACK:      slack_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic acc;
	assign s_tready = cmd.take;
	assign acc = s_tvalid && cmd.take;

	// Obstacle table: {ball, y, x}
	logic [ENT-1:0] mem [MAX_OBSTACLES];
	logic [ENT-1:0] rd_q;
	logic [JW-1:0]  j_q;
	logic [sob_pkg::INDEX_W-1:0] ld_idx;
	assign ld_idx = s_tdata[O_IDX +: sob_pkg::INDEX_W];

	always_ff @(posedge clk) begin
		if (acc && s_tuser == sob_pkg::FUNC_LOAD && 32'(ld_idx) < MAX_OBSTACLES) begin
			mem[AW'(32'(ld_idx))] <= {s_tdata[O_BALL], s_tdata[O_OY +: C], s_tdata[O_OX +: C]};
		end
		if (cmd.rd) begin
			rd_q <= mem[j_q[AW-1:0]];
		end
	end

	// Segment registers
	logic signed [C-1:0]  sx_q, sy_q, ex_q, ey_q;
	logic signed [DW-1:0] dx, dy;
	always_ff @(posedge clk) begin
		if (acc) begin
			sx_q <= s_tdata[O_SX +: C];
			sy_q <= s_tdata[O_SY +: C];
			ex_q <= s_tdata[O_EX +: C];
			ey_q <= s_tdata[O_EY +: C];
		end
	end
	assign dx = DW'(ex_q) - DW'(sx_q);
	assign dy = DW'(ey_q) - DW'(sy_q);

	// Segment length squared
	logic [SQW-1:0] lp_q, lq_q;
	logic [LW-1:0]  len2_q;
	always_ff @(posedge clk) begin
		if (cmd.len_mul) begin
			lp_q <= SQW'(dx * dx);
			lq_q <= SQW'(dy * dy);
		end
		if (cmd.len_add) begin
			len2_q <= LW'(lp_q) + LW'(lq_q);
		end
	end

	// Digit-by-digit integer square root, one result bit a cycle
	logic [E-1:0]  v_q, res_q, bit_q, trial;
	logic [KW-1:0] k_q;
	assign trial = res_q + bit_q;
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			v_q   <= E'(len2_q);
			res_q <= '0;
			bit_q <= E'(1) << (E - 2);
			k_q   <= '0;
		end else if (cmd.sqrt_step) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
			k_q   <= k_q + KW'(1);
		end
	end

	// Range window and its square
	logic [WW-1:0]   w_q;
	logic [2*WW-1:0] wsq_q;
	always_ff @(posedge clk) begin
		if (cmd.win) w_q <= WW'(res_q[K-1:0]) + WW'(slack_q);
		if (cmd.wsq) wsq_q <= WSW'(w_q) * WSW'(w_q);
	end

	// Per-obstacle pipeline steps
	logic signed [C-1:0]  ox, oy;
	logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
	logic [sob_pkg::RADIUS_W-1:0] r_q;
	logic [SQW-1:0] m1_q, m2_q, m3_q, m4_q;
	logic signed [SQW-1:0] c1_q, c2_q;
	logic [2*sob_pkg::RADIUS_W-1:0] rr_q;
	logic [LW-1:0] d1_q, d2_q;
	logic signed [CRW-1:0] cr;
	logic [CRW-1:0] acr_q;
	logic in_q;
	logic [PW-1:0] a2_q, rl_q;

	assign ox = rd_q[C-1:0];
	assign oy = rd_q[2*C-1:C];
	assign cr = CRW'(c1_q) - CRW'(c2_q);

	always_ff @(posedge clk) begin
		if (cmd.dif) begin
			ax_q <= DW'(ox) - DW'(sx_q);
			ay_q <= DW'(oy) - DW'(sy_q);
			bx_q <= DW'(ox) - DW'(ex_q);
			by_q <= DW'(oy) - DW'(ey_q);
			r_q  <= rd_q[ENT-1] ? ball_r_q : robot_r_q;
		end
		if (cmd.mul) begin
			m1_q <= SQW'(ax_q * ax_q);
			m2_q <= SQW'(ay_q * ay_q);
			m3_q <= SQW'(bx_q * bx_q);
			m4_q <= SQW'(by_q * by_q);
			c1_q <= SQW'(dx * ay_q);
			c2_q <= SQW'(dy * ax_q);
			rr_q <= RRW'(r_q) * RRW'(r_q);
		end
		if (cmd.add) begin
			d1_q  <= LW'(m1_q) + LW'(m2_q);
			d2_q  <= LW'(m3_q) + LW'(m4_q);
			acr_q <= cr[CRW-1] ? CRW'(-cr) : CRW'(cr);
		end
		if (cmd.mul2) begin
			in_q <= (PW'(d1_q) < PW'(wsq_q)) && (PW'(d2_q) < PW'(wsq_q));
			a2_q <= PW'(acr_q * acr_q);
			rl_q <= PW'(rr_q * len2_q);
		end
	end

	// Obstacle counter
	logic [JW-1:0] n_lim;
	assign n_lim = (32'(count_q) < MAX_OBSTACLES) ? JW'(count_q) : JW'(MAX_OBSTACLES);
	always_ff @(posedge clk) begin
		if (acc) j_q <= '0;
		else if (cmd.cmp) j_q <= j_q + JW'(1);
	end

	logic hit;
	assign hit = in_q && (a2_q <= rl_q);

	// Result word
	logic mval_q, blk_q, wq_q;
	logic [sob_pkg::INDEX_W-1:0] hidx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mval_q <= 1'b0;
		end else if (cmd.emit) begin
			mval_q <= 1'b1;
		end else if (m_tready) begin
			mval_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (acc) begin
			blk_q  <= 1'b0;
			hidx_q <= '0;
			wq_q   <= s_tuser;
		end else if (cmd.cmp && hit) begin
			blk_q  <= 1'b1;
			hidx_q <= sob_pkg::INDEX_W'(32'(j_q));
		end
	end

	assign m_tvalid = mval_q;
	assign m_tdata  = {3'b000, hidx_q, blk_q};
	assign m_tuser  = wq_q;

	assign st.acc       = acc;
	assign st.is_query  = (s_tuser == sob_pkg::FUNC_QUERY);
	assign st.zero_len  = (len2_q == '0);
	assign st.sqrt_last = (k_q == KW'(K - 1));
	assign st.j_end     = (j_q >= n_lim);
	assign st.hit       = hit;
	assign st.out_busy  = mval_q;

endmodule

@@ sv/segment_obstacle_block_check.sv @@
// Channel   Dir  Handshake          Payload
// s         in   s_tvalid/s_tready  s_tdata (load or query), s_tuser (func)
// m         out  m_tvalid/m_tready  m_tdata (blocked, hit_index), m_tuser (was_query)
// cfg       in   cfg_we             cfg_addr, cfg_data
//
// A load writes its table entry when the index is in range, then emits its result
// word. A query squares the segment deltas, runs the iterative square root unless
// the length is zero, sets the range window and walks the obstacles through the
// six-step per-obstacle multiply/compare sequence until a hit or the count, then emits.
// One item is in flight at a time; s_tready stays low while the result word waits.
// Reset clears control and config registers; the obstacle table is not cleared.
module segment_obstacle_block_check #(
	parameter int MAX_OBSTACLES = 16,
	parameter int COORD_BITS    = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [sob_pkg::CFG_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// entry_index, obstacle_x, obstacle_y, obstacle_is_ball, start_x, start_y,
	// end_x, end_y, zero fill
	input  logic [((6*COORD_BITS+5+7)/8)*8-1:0] s_tdata,
	// func
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// blocked, hit_index, zero fill
	output logic [7:0] m_tdata,
	// was_query
	output logic m_tuser
);

	localparam int IN_W = ((6 * COORD_BITS + 5 + 7) / 8) * 8;

	sob_pkg::cmd_t    cmd;
	sob_pkg::status_t st;

	sob_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	sob_dp #(
		.MAX_OBSTACLES (MAX_OBSTACLES),
		.COORD_BITS    (COORD_BITS),
		.IN_W          (IN_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

@@ sv/sob_checker.sv @@
`include "assert_macros.svh"

module sob_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);

	// result word holds until taken
	`SOB_ASSERT_NEXT(a_m_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
	// busy right after taking a word
	`SOB_ASSERT_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready, "took two words")
	// no intake while a result waits
	`SOB_ASSERT_NOW(a_one, clk, arst_n, m_tvalid, !s_tready, "intake with result pending")
	// load acknowledge carries no hit
	`SOB_ASSERT_NOW(a_ack, clk, arst_n, m_tvalid && !m_tuser, m_tdata[4:0] == 5'd0, "bad ack")

endmodule

bind segment_obstacle_block_check sob_checker u_sob_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
